/* rtl/core/tisb_pkg.sv */
// Shared types, constants and helper functions for the IPv4/TCP segment builder.
// Used by tisb_front, tisb_dq, tisb_back and tcp_ipv4_segment_builder_unit.
// No dependencies.
package tisb_pkg;

  localparam int MAX_PAYLOAD_DEF = 256;
  localparam int HDR_BYTES       = 60;
  localparam int PLEN_W          = 9;   // holds payload lengths up to 511
  localparam int TOT_W           = 10;  // holds datagram lengths up to 1023
  localparam int WCNT_W          = 6;   // word index within one datagram
  localparam int HDR_WORDS       = 7;   // words that carry header bytes only

  // Segment kinds.
  localparam logic [2:0] KIND_DATA   = 3'd0;
  localparam logic [2:0] KIND_SYN    = 3'd1;
  localparam logic [2:0] KIND_ACK    = 3'd2;
  localparam logic [2:0] KIND_ACKRST = 3'd3;
  localparam logic [2:0] KIND_RST    = 3'd4;

  // TCP flag bytes.
  localparam logic [7:0] FLAGS_PSH_ACK = 8'h18;
  localparam logic [7:0] FLAGS_SYN     = 8'h02;
  localparam logic [7:0] FLAGS_ACK     = 8'h10;
  localparam logic [7:0] FLAGS_ACK_RST = 8'h14;
  localparam logic [7:0] FLAGS_RST     = 8'h04;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SRC_ADDR = 2'd0;
  localparam logic [1:0] CFG_DST_ADDR = 2'd1;
  localparam logic [1:0] CFG_SRC_PORT = 2'd2;
  localparam logic [1:0] CFG_DST_PORT = 2'd3;

  // Fixed header pieces.
  localparam logic [15:0] IP_VER_TOS    = 16'h4500;
  localparam logic [15:0] IP_TTL_PROTO  = 16'h4006;
  localparam logic [15:0] TCP_OFFSET    = 16'hA000;
  localparam logic [15:0] TCP_WINDOW    = 16'd5840;
  localparam logic [15:0] TCP_PROTO     = 16'd6;
  localparam logic [9:0]  IP_HDR_BYTES  = 10'd20;
  localparam logic [63:0] SYN_OPTIONS   = 64'h0204_0030_0402_0000;
  localparam logic [15:0] SYN_OPT_SUM   = 16'h0636;

  typedef struct packed {
    logic [2:0]        kind;
    logic [31:0]       seq;
    logic [31:0]       ack;
    logic [15:0]       ident;
    logic [PLEN_W-1:0] plen;
    logic [15:0]       psum;
    logic              ovf;
    logic              bank;
  } desc_t;

  // Unused kind codes behave as a plain ACK.
  function automatic logic [2:0] norm_kind(input logic [2:0] k);
    logic [2:0] r;
    r = (k > KIND_RST) ? KIND_ACK : k;
    return r;
  endfunction

  function automatic logic [7:0] tcp_flags(input logic [2:0] k);
    logic [7:0] f;
    case (k)
      KIND_DATA:   f = FLAGS_PSH_ACK;
      KIND_SYN:    f = FLAGS_SYN;
      KIND_ACKRST: f = FLAGS_ACK_RST;
      KIND_RST:    f = FLAGS_RST;
      default:     f = FLAGS_ACK;
    endcase
    return f;
  endfunction

  // Two end-around-carry folds of a one's-complement sum.
  function automatic logic [15:0] fold16(input logic [20:0] s);
    logic [16:0] t;
    logic [16:0] u;
    t = 17'(s[15:0]) + 17'(s[20:16]);
    u = 17'(t[15:0]) + 17'(t[16]);
    return u[15:0];
  endfunction

endpackage

/* rtl/core/tcp_ipv4_segment_builder_unit.sv */
// IPv4/TCP segment builder, top level: configuration registers, front end,
// request queue and back end. Depends on tisb_pkg, tisb_front, tisb_dq, tisb_back.
//
// Input channel: one item per beat, accepted when push is high and full is low.
// The first item of a request latches kind, sequence, ack and identification;
// data items add one payload byte each; the item with in_last_item closes the
// request. Items are taken one per cycle while full is low.
// Result channel: one 64-bit datagram word per beat, shown while empty is low
// and taken when pop is high. A datagram is 8 to 40 words (60 + payload bytes).
// After the closing item, the first word passes through the queue, the checksum
// states SUM1 to SUM3 and the output register, then one word per cycle while pop
// stays high. Between two datagrams the result side sees no new word while the
// next checksums are formed.
// The payload store has two banks, so one datagram can be sent while the
// next request is collected; full rises only when both banks hold datagrams
// not yet sent. When the receiver stalls, the held word stays on the ports and
// the front end keeps taking items until that point.
// Reset clears control state and the configuration registers; the payload
// store is not cleared. Configuration writes take effect on the next cycle.
module tcp_ipv4_segment_builder_unit #(
  parameter int MAX_PAYLOAD = tisb_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_seq_num,
  input  logic [31:0] in_ack_number,
  input  logic [15:0] in_ip_ident,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_data,
  input  logic        in_last_item,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_word,
  output logic [3:0]  out_valid_bytes,
  output logic        out_last_word,
  output logic [8:0]  out_datagram_length,
  output logic        out_truncated
);

  localparam int AW = $clog2(2 * ((MAX_PAYLOAD + 7) / 8));

  logic [31:0]     src_addr_r;
  logic [31:0]     dst_addr_r;
  logic [15:0]     src_port_r;
  logic [15:0]     dest_port_r;

  logic            dq_push;
  tisb_pkg::desc_t dq_desc;
  logic            dq_pop;
  tisb_pkg::desc_t dq_head;
  logic            dq_empty;
  logic            dq_full;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [63:0]     mem_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_addr_r  <= '0;
      dst_addr_r  <= '0;
      src_port_r  <= '0;
      dest_port_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tisb_pkg::CFG_SRC_ADDR: src_addr_r  <= cfg_data;
        tisb_pkg::CFG_DST_ADDR: dst_addr_r  <= cfg_data;
        tisb_pkg::CFG_SRC_PORT: src_port_r  <= cfg_data[15:0];
        tisb_pkg::CFG_DST_PORT: dest_port_r <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Both payload banks busy means the front end has nowhere to write.
  assign full = dq_full;

  tisb_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (dq_full),
    .in_req_type   (in_req_type),
    .in_seq_num    (in_seq_num),
    .in_ack_number (in_ack_number),
    .in_ip_ident   (in_ip_ident),
    .in_data_byte  (in_data_byte),
    .in_has_data   (in_has_data),
    .in_last_item  (in_last_item),
    .dq_push       (dq_push),
    .dq_desc       (dq_desc),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata)
  );

  tisb_dq u_dq (
    .clk      (clk),
    .rst_n    (rst_n),
    .dq_push  (dq_push),
    .dq_desc  (dq_desc),
    .dq_pop   (dq_pop),
    .dq_head  (dq_head),
    .dq_empty (dq_empty),
    .dq_full  (dq_full)
  );

  tisb_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .src_addr            (src_addr_r),
    .dst_addr            (dst_addr_r),
    .src_port            (src_port_r),
    .dest_port           (dest_port_r),
    .mem_we              (mem_we),
    .mem_waddr           (mem_waddr),
    .mem_wdata           (mem_wdata),
    .dq_head             (dq_head),
    .dq_empty            (dq_empty),
    .dq_pop              (dq_pop),
    .pop                 (pop),
    .empty               (empty),
    .out_word            (out_word),
    .out_valid_bytes     (out_valid_bytes),
    .out_last_word       (out_last_word),
    .out_datagram_length (out_datagram_length),
    .out_truncated       (out_truncated)
  );

endmodule

/* rtl/core/tisb_front.sv */
// Front end of the segment builder: takes request items, latches the header
// fields, packs payload bytes into 64-bit words and keeps the payload sum.
// Depends on tisb_pkg.
module tisb_front #(
  parameter int MAX_PAYLOAD = tisb_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic                  full,
  input  logic [2:0]            in_req_type,
  input  logic [31:0]           in_seq_num,
  input  logic [31:0]           in_ack_number,
  input  logic [15:0]           in_ip_ident,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_has_data,
  input  logic                  in_last_item,
  output logic                  dq_push,
  output tisb_pkg::desc_t       dq_desc,
  output logic                  mem_we,
  output logic [$clog2(2*((MAX_PAYLOAD+7)/8))-1:0] mem_waddr,
  output logic [63:0]           mem_wdata
);

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 8);
  localparam int PW    = (MAX_PAYLOAD + 7) / 8;
  localparam int AW    = $clog2(2 * PW);

  logic              in_req_r;
  logic [2:0]        kind_r;
  logic [31:0]       seq_r;
  logic [31:0]       ack_r;
  logic [15:0]       ident_r;
  logic [CNT_W-1:0]  count_r;
  logic [15:0]       psum_r;
  logic              ovf_r;
  logic              bank_r;
  logic [63:0]       asm_r;

  logic              acc;
  logic              first;
  logic [2:0]        kind_now;
  logic [31:0]       seq_now;
  logic [31:0]       ack_now;
  logic [15:0]       ident_now;
  logic              data_byte_seen;
  logic              room;
  logic              byte_ok;
  logic              byte_drop;
  logic [2:0]        lane;
  logic [16:0]       term;
  logic [63:0]       asm_nxt;
  logic [CNT_W-1:0]  count_nxt;
  logic [15:0]       psum_nxt;
  logic              ovf_nxt;

  assign acc       = push & ~full;
  assign first     = ~in_req_r;
  assign kind_now  = first ? tisb_pkg::norm_kind(in_req_type) : kind_r;
  assign seq_now   = first ? in_seq_num : seq_r;
  assign ack_now   = first ? in_ack_number : ack_r;
  assign ident_now = first ? in_ip_ident : ident_r;

  assign data_byte_seen = acc & (kind_now == tisb_pkg::KIND_DATA) & in_has_data;
  assign room           = count_r < CNT_W'(MAX_PAYLOAD);
  assign byte_ok        = data_byte_seen & room;
  assign byte_drop      = data_byte_seen & ~room;
  assign lane           = count_r[2:0];

  // Even payload offsets are the high byte of a 16-bit checksum word.
  assign term = lane[0] ? {9'b0, in_data_byte} : {1'b0, in_data_byte, 8'b0};

  always_comb begin
    asm_nxt = asm_r;
    for (int i = 0; i < 8; i++) begin
      if (lane == 3'(i)) begin
        asm_nxt[63-8*i -: 8] = in_data_byte;
      end
    end
  end

  assign count_nxt = byte_ok ? count_r + CNT_W'(1) : count_r;
  assign psum_nxt  = byte_ok ? tisb_pkg::fold16(21'(psum_r) + 21'(term)) : psum_r;
  assign ovf_nxt   = ovf_r | byte_drop;

  // The partly filled word is written back on every byte that is kept, so the store
  // always holds the payload seen so far.
  assign mem_we    = byte_ok;
  assign mem_waddr = (bank_r ? AW'(PW) : AW'(0)) + AW'(count_r[CNT_W-1:3]);
  assign mem_wdata = asm_nxt;

  assign dq_push = acc & in_last_item;
  always_comb begin
    dq_desc       = '0;
    dq_desc.kind  = kind_now;
    dq_desc.seq   = seq_now;
    dq_desc.ack   = (kind_now == tisb_pkg::KIND_SYN) ? 32'd0 : ack_now;
    dq_desc.ident = ident_now;
    dq_desc.plen  = (kind_now == tisb_pkg::KIND_DATA) ?
                    tisb_pkg::PLEN_W'(count_nxt) : '0;
    dq_desc.psum  = psum_nxt;
    dq_desc.ovf   = ovf_nxt;
    dq_desc.bank  = bank_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_req_r <= 1'b0;
      count_r  <= '0;
      psum_r   <= '0;
      ovf_r    <= 1'b0;
      bank_r   <= 1'b0;
    end else if (acc) begin
      if (in_last_item) begin
        in_req_r <= 1'b0;
        count_r  <= '0;
        psum_r   <= '0;
        ovf_r    <= 1'b0;
        bank_r   <= ~bank_r;
      end else begin
        in_req_r <= 1'b1;
        count_r  <= count_nxt;
        psum_r   <= psum_nxt;
        ovf_r    <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      kind_r  <= kind_now;
      seq_r   <= seq_now;
      ack_r   <= ack_now;
      ident_r <= ident_now;
    end
    if (byte_ok) begin
      asm_r <= asm_nxt;
    end
  end

endmodule

/* rtl/core/tisb_dq.sv */
// Two-entry request queue between front and back; the head stays in place
// until the back end has sent the last word of that datagram.
// Depends on tisb_pkg.
module tisb_dq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            dq_push,
  input  tisb_pkg::desc_t dq_desc,
  input  logic            dq_pop,
  output tisb_pkg::desc_t dq_head,
  output logic            dq_empty,
  output logic            dq_full
);

  tisb_pkg::desc_t entry_r [2];
  logic            wp_r;
  logic            rp_r;
  logic [1:0]      cnt_r;

  assign dq_head  = entry_r[rp_r];
  assign dq_empty = (cnt_r == 2'd0);
  assign dq_full  = (cnt_r == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (dq_push) begin
        wp_r <= ~wp_r;
      end
      if (dq_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(dq_push) - 2'(dq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (dq_push) begin
      entry_r[wp_r] <= dq_desc;
    end
  end

endmodule

/* rtl/core/tisb_back.sv */
// Back end of the segment builder: holds the payload store, works out both
// checksums in states SUM1 to SUM3 and streams the datagram as 64-bit words.
// Depends on tisb_pkg.
module tisb_back #(
  parameter int MAX_PAYLOAD = tisb_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [31:0]           src_addr,
  input  logic [31:0]           dst_addr,
  input  logic [15:0]           src_port,
  input  logic [15:0]           dest_port,
  input  logic                  mem_we,
  input  logic [$clog2(2*((MAX_PAYLOAD+7)/8))-1:0] mem_waddr,
  input  logic [63:0]           mem_wdata,
  input  tisb_pkg::desc_t       dq_head,
  input  logic                  dq_empty,
  output logic                  dq_pop,
  input  logic                  pop,
  output logic                  empty,
  output logic [63:0]           out_word,
  output logic [3:0]            out_valid_bytes,
  output logic                  out_last_word,
  output logic [8:0]            out_datagram_length,
  output logic                  out_truncated
);

  localparam int PW = (MAX_PAYLOAD + 7) / 8;
  localparam int AW = $clog2(2 * PW);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM1 = 5'b00010,
    ST_SUM2 = 5'b00100,
    ST_SUM3 = 5'b01000,
    ST_EMIT = 5'b10000
  } bstate_t;

  logic [63:0] mem [2*PW];

  bstate_t                       state_r;
  logic [17:0]                   acc_a_r;
  logic [17:0]                   acc_b_r;
  logic [18:0]                   acc_c_r;
  logic [17:0]                   acc_d_r;
  logic [16:0]                   acc_e_r;
  logic [20:0]                   ip_sum_r;
  logic [20:0]                   tcp_sum_r;
  logic [15:0]                   ip_ck_r;
  logic [15:0]                   tcp_ck_r;
  logic [tisb_pkg::WCNT_W-1:0]   w_r;
  logic [31:0]                   prev_lo_r;
  logic [63:0]                   rd_data_r;
  logic                          out_vld_r;
  logic [63:0]                   out_word_r;
  logic [3:0]                    nbytes_r;
  logic                          last_r;
  logic [8:0]                    dlen_r;
  logic                          trunc_r;

  logic [tisb_pkg::TOT_W-1:0]    total;
  logic [tisb_pkg::TOT_W-1:0]    tcp_len;
  logic [tisb_pkg::TOT_W-1:0]    rem;
  logic                          is_last;
  logic [3:0]                    nbytes;
  logic                          is_syn;
  logic [15:0]                   flag_word;
  logic [63:0]                   word;
  logic [63:0]                   mask;
  logic                          adv;
  logic [tisb_pkg::WCNT_W-1:0]   next_pw;
  logic [AW-1:0]                 base;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;

  assign total   = tisb_pkg::TOT_W'(tisb_pkg::HDR_BYTES) + tisb_pkg::TOT_W'(dq_head.plen);
  assign tcp_len = total - tisb_pkg::IP_HDR_BYTES;
  assign is_syn  = (dq_head.kind == tisb_pkg::KIND_SYN);
  assign flag_word = tisb_pkg::TCP_OFFSET | {8'h00, tisb_pkg::tcp_flags(dq_head.kind)};
  assign base    = dq_head.bank ? AW'(PW) : AW'(0);

  // Bytes still to send, counted from the start of the current word.
  assign rem     = total - tisb_pkg::TOT_W'({w_r, 3'b000});
  assign is_last = (rem <= tisb_pkg::TOT_W'(8));
  assign nbytes  = is_last ? rem[3:0] : 4'd8;

  assign adv    = (state_r == ST_EMIT) & (~out_vld_r | pop);
  assign dq_pop = adv & is_last;

  // Payload word for the next output word; the payload starts halfway
  // through the last header word, so output word k uses payload words
  // k-8 and k-7.
  assign next_pw = w_r - tisb_pkg::WCNT_W'(tisb_pkg::HDR_WORDS - 1);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = base;
    if (state_r == ST_SUM1) begin
      rd_en = 1'b1;
    end else if (adv && !is_last &&
                 w_r >= tisb_pkg::WCNT_W'(tisb_pkg::HDR_WORDS - 1) &&
                 next_pw < tisb_pkg::WCNT_W'(PW)) begin
      rd_en   = 1'b1;
      rd_addr = base + AW'(next_pw);
    end
  end

  always_comb begin
    case (w_r)
      tisb_pkg::WCNT_W'(0): word = {tisb_pkg::IP_VER_TOS, 16'(total), dq_head.ident, 16'h0000};
      tisb_pkg::WCNT_W'(1): word = {tisb_pkg::IP_TTL_PROTO, ip_ck_r, src_addr};
      tisb_pkg::WCNT_W'(2): word = {dst_addr, src_port, dest_port};
      tisb_pkg::WCNT_W'(3): word = {dq_head.seq, dq_head.ack};
      tisb_pkg::WCNT_W'(4): word = {flag_word, tisb_pkg::TCP_WINDOW, tcp_ck_r, 16'h0000};
      tisb_pkg::WCNT_W'(5): word = is_syn ? tisb_pkg::SYN_OPTIONS : 64'd0;
      tisb_pkg::WCNT_W'(6): word = 64'd0;
      default:              word = {prev_lo_r, rd_data_r[63:32]};
    endcase
  end

  always_comb begin
    mask = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < nbytes) begin
        mask[63-8*i -: 8] = 8'hFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (!dq_empty) begin
            state_r <= ST_SUM1;
          end
        end
        ST_SUM1: state_r <= ST_SUM2;
        ST_SUM2: state_r <= ST_SUM3;
        ST_SUM3: state_r <= ST_EMIT;
        ST_EMIT: begin
          if (adv && is_last) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_SUM1: begin
        acc_a_r <= 18'(src_addr[31:16]) + 18'(src_addr[15:0])
                 + 18'(dst_addr[31:16]) + 18'(dst_addr[15:0]);
        acc_b_r <= 18'(src_port) + 18'(dest_port)
                 + 18'(dq_head.seq[31:16]) + 18'(dq_head.seq[15:0]);
        acc_c_r <= 19'(dq_head.ack[31:16]) + 19'(dq_head.ack[15:0]) + 19'(flag_word)
                 + 19'(tisb_pkg::TCP_WINDOW)
                 + 19'(is_syn ? tisb_pkg::SYN_OPT_SUM : 16'h0000);
        acc_d_r <= 18'(tisb_pkg::IP_VER_TOS) + 18'(tisb_pkg::IP_TTL_PROTO)
                 + 18'(total) + 18'(dq_head.ident);
        acc_e_r <= 17'(tisb_pkg::TCP_PROTO) + 17'(tcp_len) + 17'(dq_head.psum);
      end
      ST_SUM2: begin
        ip_sum_r  <= 21'(acc_a_r) + 21'(acc_d_r);
        tcp_sum_r <= 21'(acc_a_r) + 21'(acc_b_r) + 21'(acc_c_r) + 21'(acc_e_r);
      end
      ST_SUM3: begin
        ip_ck_r   <= ~tisb_pkg::fold16(ip_sum_r);
        tcp_ck_r  <= ~tisb_pkg::fold16(tcp_sum_r);
        w_r       <= '0;
        prev_lo_r <= '0;
      end
      ST_EMIT: begin
        if (adv) begin
          w_r <= w_r + tisb_pkg::WCNT_W'(1);
          if (w_r >= tisb_pkg::WCNT_W'(tisb_pkg::HDR_WORDS)) begin
            prev_lo_r <= rd_data_r[31:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (pop) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r <= word & mask;
      nbytes_r   <= nbytes;
      last_r     <= is_last;
      dlen_r     <= 9'(total);
      trunc_r    <= dq_head.ovf;
    end
  end

  assign empty               = ~out_vld_r;
  assign out_word            = out_word_r;
  assign out_valid_bytes     = nbytes_r;
  assign out_last_word       = last_r;
  assign out_datagram_length = dlen_r;
  assign out_truncated       = trunc_r;

endmodule
